@@ src/tcfpi_pkg.sv @@
// shared types, constants and helpers for the three-class fenwick position index
`default_nettype none
package tcfpi_pkg;

  localparam int MAX_POS = 1024;
  localparam int PW      = 11;
  localparam int XW      = PW + 1;
  localparam int LW      = $clog2(MAX_POS);
  localparam int DEPTH   = 3 * MAX_POS;
  localparam int AW      = $clog2(DEPTH);

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_NEXT  = 2'd2,
    CMD_PREV  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLR,
    OP_XLOAD,
    OP_PF_ISSUE,
    OP_PF_ACC,
    OP_SAVE_A,
    OP_SET_DIR,
    OP_INIT_SEARCH,
    OP_STEP,
    OP_SHIFT,
    OP_UP_ISSUE,
    OP_UP_WR,
    OP_RESULT
  } op_t;

  typedef enum logic [2:0] {
    X_POS,
    X_POS_M1,
    X_HI,
    X_QPI,
    X_QMI1
  } xsel_t;

  typedef enum logic [2:0] {
    R_ZERO,
    R_COUNT,
    R_NPLUS1,
    R_QPLUS1,
    R_QMINUS1
  } rsel_t;

  typedef struct packed {
    op_t   op;
    xsel_t xsel;
    rsel_t rsel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic x_zero;
    logic x_over;
    logic add_skip;
    logic cnt_empty;
    logic next_none;
    logic prev_zero;
    logic step_ok;
    logic i_zero;
    logic eq;
    logic diff_nz;
    logic out_free;
    cmd_t cmd;
  } dp_stat_t;

  function automatic logic [PW-1:0] top_power(input logic [PW-1:0] n);
    logic [PW-1:0] p;
    p = PW'(1);
    for (int k = 0; k < PW; k++) begin
      if (n[k]) p = PW'(1) << k;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

@@ src/tcfpi_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module tcfpi_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [W-1:0]             wdata,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ src/tcfpi_dp.sv @@
// datapath: tree store, walk index, sums, search registers and result register
`default_nettype none
module tcfpi_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tcfpi_pkg::dp_cmd_t     cmd,
  output tcfpi_pkg::dp_stat_t         stat,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [1:0]             in_symbol,
  input  wire logic [10:0]            in_pos,
  input  wire logic [10:0]            in_range_end,
  input  wire logic signed [1:0]      in_delta,
  input  wire logic [10:0]            size_r,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [10:0]                 out_count,
  output logic [10:0]                 out_position
);

  localparam int PW = tcfpi_pkg::PW;
  localparam int XW = tcfpi_pkg::XW;
  localparam int LW = tcfpi_pkg::LW;
  localparam int AW = tcfpi_pkg::AW;

  tcfpi_pkg::cmd_t cmd_r;
  logic [1:0]    t_r;
  logic [PW-1:0] p_r, hi_r, n_r, acc_r, a_r, q_r, i_r;
  logic [1:0]    delta_r;
  logic [XW-1:0] x_r;
  logic          up_r;
  logic [AW-1:0] clr_r;
  logic          out_valid_r;
  logic [PW-1:0] out_count_r, out_position_r;

  logic [PW-1:0] n_c, p_c, hi_c, rdata;
  logic [XW-1:0] x_sel, lowbit, x_m1, qpi;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [PW-1:0] ram_wdata;
  logic          old0;

  always_comb begin
    if (size_r == '0) n_c = PW'(1);
    else if (size_r > PW'(tcfpi_pkg::MAX_POS)) n_c = PW'(tcfpi_pkg::MAX_POS);
    else n_c = size_r;
    case (tcfpi_pkg::cmd_t'(in_cmd))
      tcfpi_pkg::CMD_PREV:  p_c = (in_pos > n_c + PW'(1)) ? n_c + PW'(1) : in_pos;
      tcfpi_pkg::CMD_COUNT: p_c = (in_pos == '0) ? PW'(1) : in_pos;
      default:              p_c = in_pos;
    endcase
    hi_c = (in_range_end > n_c) ? n_c : in_range_end;
  end

  assign qpi    = {1'b0, q_r} + {1'b0, i_r};
  assign lowbit = x_r & (~x_r + XW'(1));
  assign x_m1   = x_r - XW'(1);
  assign old0   = (a_r == acc_r);

  always_comb begin
    case (cmd.xsel)
      tcfpi_pkg::X_POS:    x_sel = {1'b0, p_r};
      tcfpi_pkg::X_POS_M1: x_sel = {1'b0, p_r} - XW'(1);
      tcfpi_pkg::X_HI:     x_sel = {1'b0, hi_r};
      tcfpi_pkg::X_QPI:    x_sel = qpi;
      tcfpi_pkg::X_QMI1:   x_sel = {1'b0, q_r} - {1'b0, i_r} - XW'(1);
      default:             x_sel = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    ram_addr  = {t_r, x_m1[LW-1:0]};
    case (cmd.op)
      tcfpi_pkg::OP_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_r;
      end
      tcfpi_pkg::OP_UP_WR: begin
        ram_we    = 1'b1;
        ram_wdata = up_r ? rdata + PW'(1) : rdata - PW'(1);
      end
      default: ;
    endcase
  end

  tcfpi_ram #(.W(PW), .DEPTH(tcfpi_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == tcfpi_pkg::OP_CLR && clr_r != AW'(tcfpi_pkg::DEPTH - 1)) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.op == tcfpi_pkg::OP_RESULT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tcfpi_pkg::OP_LOAD: begin
        cmd_r   <= tcfpi_pkg::cmd_t'(in_cmd);
        t_r     <= (in_symbol == 2'd3) ? 2'd2 : in_symbol;
        n_r     <= n_c;
        p_r     <= p_c;
        hi_r    <= hi_c;
        delta_r <= in_delta;
      end
      tcfpi_pkg::OP_XLOAD: begin
        x_r   <= x_sel;
        acc_r <= '0;
      end
      tcfpi_pkg::OP_PF_ACC: begin
        acc_r <= acc_r + rdata;
        x_r   <= x_r - lowbit;
      end
      tcfpi_pkg::OP_SAVE_A: a_r <= acc_r;
      tcfpi_pkg::OP_SET_DIR: begin
        up_r <= old0;
        x_r  <= {1'b0, p_r};
      end
      tcfpi_pkg::OP_INIT_SEARCH: begin
        q_r <= p_r;
        i_r <= tcfpi_pkg::top_power(n_r);
      end
      tcfpi_pkg::OP_STEP: begin
        if (acc_r == a_r) begin
          q_r <= (cmd_r == tcfpi_pkg::CMD_NEXT) ? q_r + i_r : q_r - i_r;
        end
        i_r <= i_r >> 1;
      end
      tcfpi_pkg::OP_SHIFT: i_r <= i_r >> 1;
      tcfpi_pkg::OP_UP_WR: x_r <= x_r + lowbit;
      tcfpi_pkg::OP_RESULT: begin
        case (cmd.rsel)
          tcfpi_pkg::R_COUNT: begin
            out_count_r    <= a_r - acc_r;
            out_position_r <= '0;
          end
          tcfpi_pkg::R_NPLUS1: begin
            out_count_r    <= '0;
            out_position_r <= n_r + PW'(1);
          end
          tcfpi_pkg::R_QPLUS1: begin
            out_count_r    <= '0;
            out_position_r <= q_r + PW'(1);
          end
          tcfpi_pkg::R_QMINUS1: begin
            out_count_r    <= '0;
            out_position_r <= q_r - PW'(1);
          end
          default: begin
            out_count_r    <= '0;
            out_position_r <= '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.clr_done  = (clr_r == AW'(tcfpi_pkg::DEPTH - 1));
    stat.x_zero    = (x_r == '0);
    stat.x_over    = (x_r > XW'(tcfpi_pkg::MAX_POS));
    stat.add_skip  = (p_r == '0) || (p_r > n_r);
    stat.cnt_empty = (p_r > hi_r);
    stat.next_none = (p_r >= n_r);
    stat.prev_zero = (p_r == '0);
    stat.step_ok   = (cmd_r == tcfpi_pkg::CMD_NEXT) ? (qpi <= {1'b0, n_r}) : (q_r > i_r);
    stat.i_zero    = (i_r == '0);
    stat.eq        = (acc_r == a_r);
    stat.diff_nz   = (old0 && delta_r == 2'b01) || (!old0 && delta_r[1]);
    stat.out_free  = !out_valid_r || out_ready;
    stat.cmd       = cmd_r;
  end

  assign out_valid    = out_valid_r;
  assign out_count    = out_count_r;
  assign out_position = out_position_r;

endmodule
`default_nettype wire

@@ src/tcfpi_ctrl.sv @@
// controller: sequences clearing, prefix walks, updates and binary lifting searches
`default_nettype none
module tcfpi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tcfpi_pkg::dp_stat_t stat,
  output tcfpi_pkg::dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DISPATCH, S_XLOAD, S_PF_ISSUE, S_PF_ACC, S_PF_DONE,
    S_SEARCH, S_UP_ISSUE, S_UP_WR, S_RES
  } state_t;

  typedef enum logic [2:0] {
    ST_ADD_A, ST_ADD_B, ST_CNT_A, ST_CNT_B, ST_BASE, ST_PROBE
  } step_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  tcfpi_pkg::xsel_t xsel_r, xsel_nxt;
  tcfpi_pkg::rsel_t rsel_r, rsel_nxt;
  tcfpi_pkg::op_t   op;
  logic   is_next;

  assign is_next = (stat.cmd == tcfpi_pkg::CMD_NEXT);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    xsel_nxt  = xsel_r;
    rsel_nxt  = rsel_r;
    op        = tcfpi_pkg::OP_NONE;
    case (state_r)
      S_CLR: begin
        op = tcfpi_pkg::OP_CLR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op        = tcfpi_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.cmd)
          tcfpi_pkg::CMD_ADD: begin
            if (stat.add_skip) begin
              rsel_nxt  = tcfpi_pkg::R_ZERO;
              state_nxt = S_RES;
            end else begin
              xsel_nxt  = tcfpi_pkg::X_POS;
              step_nxt  = ST_ADD_A;
              state_nxt = S_XLOAD;
            end
          end
          tcfpi_pkg::CMD_COUNT: begin
            if (stat.cnt_empty) begin
              rsel_nxt  = tcfpi_pkg::R_ZERO;
              state_nxt = S_RES;
            end else begin
              xsel_nxt  = tcfpi_pkg::X_HI;
              step_nxt  = ST_CNT_A;
              state_nxt = S_XLOAD;
            end
          end
          tcfpi_pkg::CMD_NEXT: begin
            if (stat.next_none) begin
              rsel_nxt  = tcfpi_pkg::R_NPLUS1;
              state_nxt = S_RES;
            end else begin
              op        = tcfpi_pkg::OP_INIT_SEARCH;
              xsel_nxt  = tcfpi_pkg::X_POS;
              step_nxt  = ST_BASE;
              state_nxt = S_XLOAD;
            end
          end
          default: begin
            if (stat.prev_zero) begin
              rsel_nxt  = tcfpi_pkg::R_ZERO;
              state_nxt = S_RES;
            end else begin
              op        = tcfpi_pkg::OP_INIT_SEARCH;
              xsel_nxt  = tcfpi_pkg::X_POS_M1;
              step_nxt  = ST_BASE;
              state_nxt = S_XLOAD;
            end
          end
        endcase
      end
      S_XLOAD: begin
        op        = tcfpi_pkg::OP_XLOAD;
        state_nxt = S_PF_ISSUE;
      end
      S_PF_ISSUE: begin
        if (stat.x_zero) begin
          state_nxt = S_PF_DONE;
        end else begin
          op        = tcfpi_pkg::OP_PF_ISSUE;
          state_nxt = S_PF_ACC;
        end
      end
      S_PF_ACC: begin
        op        = tcfpi_pkg::OP_PF_ACC;
        state_nxt = S_PF_ISSUE;
      end
      S_PF_DONE: begin
        case (step_r)
          ST_ADD_A: begin
            op        = tcfpi_pkg::OP_SAVE_A;
            xsel_nxt  = tcfpi_pkg::X_POS_M1;
            step_nxt  = ST_ADD_B;
            state_nxt = S_XLOAD;
          end
          ST_ADD_B: begin
            if (stat.diff_nz) begin
              op        = tcfpi_pkg::OP_SET_DIR;
              state_nxt = S_UP_ISSUE;
            end else begin
              rsel_nxt  = tcfpi_pkg::R_ZERO;
              state_nxt = S_RES;
            end
          end
          ST_CNT_A: begin
            op        = tcfpi_pkg::OP_SAVE_A;
            xsel_nxt  = tcfpi_pkg::X_POS_M1;
            step_nxt  = ST_CNT_B;
            state_nxt = S_XLOAD;
          end
          ST_CNT_B: begin
            rsel_nxt  = tcfpi_pkg::R_COUNT;
            state_nxt = S_RES;
          end
          ST_BASE: begin
            op        = tcfpi_pkg::OP_SAVE_A;
            state_nxt = S_SEARCH;
          end
          default: begin
            op        = tcfpi_pkg::OP_STEP;
            state_nxt = S_SEARCH;
          end
        endcase
      end
      S_SEARCH: begin
        if (stat.i_zero) begin
          rsel_nxt  = is_next ? tcfpi_pkg::R_QPLUS1 : tcfpi_pkg::R_QMINUS1;
          state_nxt = S_RES;
        end else if (stat.step_ok) begin
          xsel_nxt  = is_next ? tcfpi_pkg::X_QPI : tcfpi_pkg::X_QMI1;
          step_nxt  = ST_PROBE;
          state_nxt = S_XLOAD;
        end else begin
          op = tcfpi_pkg::OP_SHIFT;
        end
      end
      S_UP_ISSUE: begin
        if (stat.x_over) begin
          rsel_nxt  = tcfpi_pkg::R_ZERO;
          state_nxt = S_RES;
        end else begin
          op        = tcfpi_pkg::OP_UP_ISSUE;
          state_nxt = S_UP_WR;
        end
      end
      S_UP_WR: begin
        op        = tcfpi_pkg::OP_UP_WR;
        state_nxt = S_UP_ISSUE;
      end
      S_RES: begin
        if (stat.out_free) begin
          op        = tcfpi_pkg::OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      step_r  <= ST_ADD_A;
      xsel_r  <= tcfpi_pkg::X_POS;
      rsel_r  <= tcfpi_pkg::R_ZERO;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      xsel_r  <= xsel_nxt;
      rsel_r  <= rsel_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign cmd.op   = op;
  assign cmd.xsel = xsel_r;
  assign cmd.rsel = rsel_r;

endmodule
`default_nettype wire

@@ src/three_class_fenwick_position_index.sv @@
// top level: configuration register, controller and datapath
// Position index over three mark classes held in Fenwick trees.
// Input channel in_*: one command per item (add, count range, find next, find
// previous). Result channel out_*: exactly one result item per input item,
// count and position, held in an output register until taken.
// Configuration: size_in_use at byte address 0 over the APB-style port, to be
// written only while the block is idle; the block itself does not enforce it.
// One item is handled at a time by a controller walking a single-port tree
// memory. Add: two prefix walks and, when the mark changes, an update walk.
// Count: two prefix walks. Next and previous: one prefix walk for the base
// plus up to log2(n)+1 lifting probes of one prefix walk each.
// After reset a clearing pass writes all 3072 tree cells with in_ready low.
// If the receiver stalls, the finished result waits in the output register
// and the next item may be accepted; its own result waits until the
// register is free.
`default_nettype none
module three_class_fenwick_position_index (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [1:0]        in_symbol,
  input  wire logic [10:0]       in_pos,
  input  wire logic [10:0]       in_range_end,
  input  wire logic signed [1:0] in_delta,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [10:0]            out_count,
  output logic [10:0]            out_position,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [10:0] size_r;
  tcfpi_pkg::dp_cmd_t  dp_cmd;
  tcfpi_pkg::dp_stat_t dp_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 11'(tcfpi_pkg::MAX_POS);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      size_r <= pwdata[10:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {21'd0, size_r};

  tcfpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  tcfpi_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (dp_cmd),
    .stat         (dp_stat),
    .in_cmd       (in_cmd),
    .in_symbol    (in_symbol),
    .in_pos       (in_pos),
    .in_range_end (in_range_end),
    .in_delta     (in_delta),
    .size_r       (size_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_count    (out_count),
    .out_position (out_position)
  );

endmodule
`default_nettype wire

@@ tb/sv/tcfpi_checker.sv @@
// result checker: models the marks of the three classes and compares every result item
`timescale 1ns / 1ps
module tcfpi_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [1:0]        in_symbol,
  input  wire logic [10:0]       in_pos,
  input  wire logic [10:0]       in_range_end,
  input  wire logic signed [1:0] in_delta,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [10:0]       out_count,
  input  wire logic [10:0]       out_position,
  input  wire logic              cfg_write,
  input  wire logic [10:0]       cfg_size,
  output int                     fail_count,
  output int                     pending_results,
  output int                     results_seen
);

  typedef struct packed {
    logic [10:0] count;
    logic [10:0] position;
  } answer_t;

  bit      marks [3][1:tcfpi_pkg::MAX_POS];
  int      size_reg;
  answer_t answer_q[$];

  assign pending_results = answer_q.size();

  function automatic int live_size();
    if (size_reg < 1) return 1;
    if (size_reg > tcfpi_pkg::MAX_POS) return tcfpi_pkg::MAX_POS;
    return size_reg;
  endfunction

  function automatic int marks_between(int cls, int lo, int hi);
    int s;
    s = 0;
    for (int k = lo; k <= hi; k++) s += marks[cls][k];
    return s;
  endfunction

  function automatic answer_t predict_answer(tcfpi_pkg::cmd_t c, int cls, int p, int re,
                                             int d);
    answer_t a;
    int n, lo, hi, v;
    a = '0;
    n = live_size();
    case (c)
      tcfpi_pkg::CMD_ADD: begin
        if (p >= 1 && p <= n) begin
          v = marks[cls][p] + d;
          marks[cls][p] = (v > 0);
        end
      end
      tcfpi_pkg::CMD_COUNT: begin
        lo = (p < 1) ? 1 : p;
        hi = (re > n) ? n : re;
        a.count = (lo > hi) ? 11'd0 : 11'(marks_between(cls, lo, hi));
      end
      tcfpi_pkg::CMD_NEXT: begin
        v = n + 1;
        for (int k = p + 1; k <= n; k++)
          if (marks[cls][k]) begin
            v = k;
            break;
          end
        a.position = (p >= n) ? 11'(n + 1) : 11'(v);
      end
      default: begin
        v = 0;
        hi = (p > n + 1) ? n + 1 : p;
        for (int k = hi - 1; k >= 1; k--)
          if (marks[cls][k]) begin
            v = k;
            break;
          end
        a.position = 11'(v);
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t e;
    if (!rst_n) begin
      foreach (marks[i, j]) marks[i][j] = 0;
      size_reg <= tcfpi_pkg::MAX_POS;
      fail_count <= 0;
      results_seen <= 0;
      answer_q.delete();
    end else begin
      if (cfg_write) size_reg <= cfg_size;
      if (in_valid && in_ready)
        answer_q.push_back(predict_answer(tcfpi_pkg::cmd_t'(in_cmd),
                                          (in_symbol > 2) ? 2 : in_symbol,
                                          in_pos, in_range_end, int'(in_delta)));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (answer_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result item count=%0d position=%0d",
                                        out_count, out_position);
          fail_count <= fail_count + 1;
        end else begin
          e = answer_q.pop_front();
          if (e.count !== out_count || e.position !== out_position) begin
            if (fail_count < 10)
              $display("result mismatch: count exp %0d got %0d, position exp %0d got %0d",
                       e.count, out_count, e.position, out_position);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
// testbench top: clock, reset, stimulus, configuration writes and verdict
`timescale 1ns / 1ps
module tb_top;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [1:0] in_cmd = tcfpi_pkg::CMD_ADD, in_symbol = 0;
  logic [10:0] in_pos = 0, in_range_end = 0, out_count, out_position;
  logic signed [1:0] in_delta = 0;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;
  int fail_count, pending_results, results_seen;
  int items_sent = 0, idle_pct = 37, hold_cycles = 0, quiet = 0;
  bit pressure_done = 0;

  localparam logic [2:0] SIZE_ADDR = 3'd0;
  localparam int WATCHDOG = 20000;

  always #6 clk = ~clk;

  three_class_fenwick_position_index dut (.*);

  tcfpi_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_symbol, .in_pos, .in_range_end,
    .in_delta, .out_valid, .out_ready, .out_count, .out_position,
    .cfg_write(psel && penable && pwrite && pready && paddr == SIZE_ADDR),
    .cfg_size(pwdata[10:0]), .fail_count, .pending_results, .results_seen);

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else if (!pressure_done && items_sent >= 700 && out_valid) begin
      pressure_done <= 1;
      hold_cycles <= 3000;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)) && hold_cycles == 0)
      quiet <= quiet + 1;
    else
      quiet <= 0;
    if (quiet > WATCHDOG) begin
      $display("watchdog expired with %0d results pending", pending_results);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] c, logic [1:0] s, logic [10:0] p, logic [10:0] re,
                           logic signed [1:0] d);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_symbol <= s;
    in_pos <= p;
    in_range_end <= re;
    in_delta <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic stop_items();
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_size(logic [10:0] v);
    stop_items();
    while (pending_results != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    paddr <= SIZE_ADDR;
    pwdata <= {21'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic random_phase(int num, int n);
    int p;
    for (int k = 0; k < num; k++) begin
      p = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(n + 1);
      send_item(2'($urandom_range(3)), 2'($urandom_range(3)), p[10:0],
                ($urandom_range(9) == 0) ? 11'($urandom_range(2047)) : 11'($urandom_range(n + 1)),
                ($urandom_range(3) == 0) ? 2'sb10 : 2'($urandom_range(3)));
      if (k == num / 2) idle_pct = (idle_pct == 0) ? 37 : 0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    send_item(tcfpi_pkg::CMD_NEXT, 0, 0, 0, 0);
    send_item(tcfpi_pkg::CMD_PREV, 1, 1025, 0, 0);
    send_item(tcfpi_pkg::CMD_ADD, 0, 1, 0, 1);
    send_item(tcfpi_pkg::CMD_ADD, 1, 1024, 0, 1);
    send_item(tcfpi_pkg::CMD_ADD, 3, 512, 0, 1);
    send_item(tcfpi_pkg::CMD_ADD, 0, 1, 0, 1);
    send_item(tcfpi_pkg::CMD_ADD, 2, 0, 0, 1);
    send_item(tcfpi_pkg::CMD_ADD, 2, 1025, 0, 1);
    send_item(tcfpi_pkg::CMD_COUNT, 0, 0, 2047, 0);
    send_item(tcfpi_pkg::CMD_COUNT, 1, 1024, 1024, 0);
    send_item(tcfpi_pkg::CMD_COUNT, 2, 600, 10, 0);
    send_item(tcfpi_pkg::CMD_NEXT, 0, 0, 0, 0);
    send_item(tcfpi_pkg::CMD_NEXT, 2, 1024, 0, 0);
    send_item(tcfpi_pkg::CMD_NEXT, 1, 2047, 0, 0);
    send_item(tcfpi_pkg::CMD_PREV, 1, 2047, 0, 0);
    send_item(tcfpi_pkg::CMD_PREV, 2, 0, 0, 0);
    send_item(tcfpi_pkg::CMD_PREV, 3, 1000, 0, 0);
    send_item(tcfpi_pkg::CMD_ADD, 0, 1, 0, 2'sb10);
    send_item(tcfpi_pkg::CMD_ADD, 1, 1024, 0, -1);
    send_item(tcfpi_pkg::CMD_COUNT, 0, 1, 1024, 0);
    random_phase(500, 1024);
    write_size(1);
    random_phase(150, 1);
    write_size(0);
    random_phase(100, 1);
    write_size(16);
    random_phase(400, 16);
    write_size(2047);
    random_phase(150, 1024);
    write_size(100);
    random_phase(300, 100);
    stop_items();
    while (pending_results != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("sent %0d items, checked %0d results over sizes 1024/1/0/16/2047/100",
             items_sent, results_seen);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
